// ===== rtl/dns_redirect_nat_rewriter_unit_macros.svh =====
// Assertion macros shared by the DNS redirect NAT rewriter modules.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef DNS_REDIRECT_NAT_REWRITER_UNIT_MACROS_SVH
`define DNS_REDIRECT_NAT_REWRITER_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define DNR_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("dnr assertion failed");

// Next-cycle implication, checked outside reset.
`define DNR_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("dnr assertion failed");

`endif

// ===== rtl/dnr_pkg.sv =====
// Shared types, constants and helper functions of the DNS redirect NAT rewriter.
// No dependencies; used by every module of the block.
package dnr_pkg;

    // Protocol and header constants.
    localparam logic [15:0] DNS_PORT     = 16'd53;
    localparam logic [31:0] DEFAULT_MARK = 32'h0000_0066;
    localparam logic [7:0]  PROTO_TCP    = 8'd6;
    localparam logic [7:0]  PROTO_UDP    = 8'd17;
    localparam logic [3:0]  IP_V4        = 4'd4;
    localparam logic [3:0]  MIN_IHL      = 4'd5;

    // Direction tag of an item.
    localparam logic REQ_INGRESS = 1'b0;
    localparam logic REQ_EGRESS  = 1'b1;

    // Configuration register indexes (word address on the APB port).
    typedef enum logic [1:0] {
        REG_PACKET_MARK = 2'd0,
        REG_REDIRECT_EN = 2'd1,
        REG_SERVER_IP   = 2'd2,
        REG_SERVER_PORT = 2'd3
    } t_reg_idx;

    // Configuration as seen by the datapath.
    typedef struct packed {
        logic [31:0] packet_mark;
        logic        redirect_enable;
        logic [31:0] server_ip;
        logic [15:0] server_port;
    } t_cfg;

    // One row of the flow table.
    typedef struct packed {
        logic        valid;
        logic [55:0] key_tag;
        logic [47:0] orig_server;
    } t_flow_entry;

    // Operands of one incremental checksum update.
    typedef struct packed {
        logic [15:0] hc_ip;
        logic [15:0] hc_l4;
        logic [31:0] old_ip;
        logic [31:0] new_ip;
        logic [15:0] old_port;
        logic [15:0] new_port;
    } t_csum_req;

    // Flow key: client address, client port and protocol.
    function automatic logic [55:0] flow_key(input logic [31:0] ip, input logic [15:0] port,
                                             input logic [7:0] proto);
        return {ip, port, proto};
    endfunction

    // XOR fold of the flow key into 16 bits.
    function automatic logic [15:0] flow_fold(input logic [31:0] ip, input logic [15:0] port,
                                              input logic [7:0] proto);
        return ip[31:16] ^ ip[15:0] ^ port ^ {8'h00, proto};
    endfunction

endpackage

// ===== rtl/dnr_apb_regs.sv =====
// APB configuration registers of the DNS redirect NAT rewriter.
// Depends on dnr_pkg for the register indexes and the t_cfg type.
module dnr_apb_regs (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output dnr_pkg::t_cfg     o_cfg
);

    dnr_pkg::t_cfg r_cfg;
    logic          w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    // Register writes on the access phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.packet_mark     <= dnr_pkg::DEFAULT_MARK;
            r_cfg.redirect_enable <= 1'b0;
            r_cfg.server_ip       <= 32'd0;
            r_cfg.server_port     <= 16'd0;
        end else if (w_wr) begin
            case (dnr_pkg::t_reg_idx'(paddr[3:2]))
                dnr_pkg::REG_PACKET_MARK: r_cfg.packet_mark     <= pwdata;
                dnr_pkg::REG_REDIRECT_EN: r_cfg.redirect_enable <= pwdata[0];
                dnr_pkg::REG_SERVER_IP:   r_cfg.server_ip       <= pwdata;
                dnr_pkg::REG_SERVER_PORT: r_cfg.server_port     <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Read-back multiplexer.
    always_comb begin
        case (dnr_pkg::t_reg_idx'(paddr[3:2]))
            dnr_pkg::REG_PACKET_MARK: prdata = r_cfg.packet_mark;
            dnr_pkg::REG_REDIRECT_EN: prdata = {31'd0, r_cfg.redirect_enable};
            dnr_pkg::REG_SERVER_IP:   prdata = r_cfg.server_ip;
            dnr_pkg::REG_SERVER_PORT: prdata = {16'd0, r_cfg.server_port};
            default:                  prdata = 32'd0;
        endcase
    end

endmodule

// ===== rtl/dnr_flow_hash.sv =====
// Flow table index pipeline: XOR fold of the key, then modulo the table depth.
// Depends on dnr_pkg for the fold function; the index follows the quotient and remainder registers.
module dnr_flow_hash #(
    parameter int FLOW_ENTRIES = 1024
) (
    input  logic                            i_clk,
    input  logic [31:0]                     i_key_ip,
    input  logic [15:0]                     i_key_port,
    input  logic [7:0]                      i_key_proto,
    output logic [$clog2(FLOW_ENTRIES)-1:0] o_idx
);

    localparam int          IDX_W   = $clog2(FLOW_ENTRIES);
    localparam logic [32:0] RECIP   = 33'((64'd1 << 32) / 64'(FLOW_ENTRIES));
    localparam logic [32:0] ENT_W33 = 33'(FLOW_ENTRIES);
    localparam logic [IDX_W:0] ENT_R = (IDX_W + 1)'(FLOW_ENTRIES);

    logic [15:0]    w_h;
    logic [48:0]    w_prod;
    logic [15:0]    r_h1;
    logic [15:0]    r_q;
    logic [32:0]    w_qn;
    logic [32:0]    w_diff;
    logic [IDX_W:0] r_r0;
    logic [IDX_W:0] w_r1;

    assign w_h = dnr_pkg::flow_fold(i_key_ip, i_key_port, i_key_proto);

    // Stage one: quotient estimate by reciprocal multiply, low by at most one.
    assign w_prod = 49'(w_h) * 49'(RECIP);

    always_ff @(posedge i_clk) begin
        r_h1 <= w_h;
        r_q  <= w_prod[47:32];
    end

    // Stage two: remainder estimate, below twice the depth.
    assign w_qn   = 33'(r_q) * ENT_W33;
    assign w_diff = 33'(r_h1) - w_qn;

    always_ff @(posedge i_clk) begin
        r_r0 <= w_diff[IDX_W:0];
    end

    // One conditional subtract finishes the modulo.
    assign w_r1  = (r_r0 >= ENT_R) ? (r_r0 - ENT_R) : r_r0;
    assign o_idx = w_r1[IDX_W-1:0];

endmodule

// ===== rtl/dnr_flow_table.sv =====
// Direct-mapped flow table memory with a clearing sweep after reset.
// Depends on dnr_pkg for t_flow_entry and on the assertion macro header.
`include "dns_redirect_nat_rewriter_unit_macros.svh"
module dnr_flow_table #(
    parameter int FLOW_ENTRIES = 1024
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_rd_en,
    input  logic [$clog2(FLOW_ENTRIES)-1:0] i_rd_idx,
    output dnr_pkg::t_flow_entry            o_rd_entry,
    input  logic                            i_wr_en,
    input  logic [$clog2(FLOW_ENTRIES)-1:0] i_wr_idx,
    input  dnr_pkg::t_flow_entry            i_wr_entry,
    output logic                            o_clearing
);

    localparam int               IDX_W    = $clog2(FLOW_ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FLOW_ENTRIES - 1);

    dnr_pkg::t_flow_entry r_mem [FLOW_ENTRIES];
    dnr_pkg::t_flow_entry r_rd_entry;
    dnr_pkg::t_flow_entry w_wdata;
    logic                 r_clr_active;
    logic [IDX_W-1:0]     r_clr_idx;
    logic                 w_we;
    logic [IDX_W-1:0]     w_waddr;

    // Clearing sweep: one row per cycle, all rows invalid when it ends.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_active <= 1'b1;
            r_clr_idx    <= '0;
        end else if (r_clr_active) begin
            r_clr_idx <= r_clr_idx + 1'b1;
            if (r_clr_idx == LAST_IDX) begin
                r_clr_active <= 1'b0;
            end
        end
    end

    // The sweep owns the write port while it runs.
    assign w_we    = r_clr_active || i_wr_en;
    assign w_waddr = r_clr_active ? r_clr_idx : i_wr_idx;
    assign w_wdata = r_clr_active ? '0 : i_wr_entry;

    // Single write port, single registered read port.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (i_rd_en) begin
            r_rd_entry <= r_mem[i_rd_idx];
        end
    end

    assign o_rd_entry = r_rd_entry;
    assign o_clearing = r_clr_active;

    // No insert may be requested while the sweep still runs.
    `DNR_ASSERT_IMP(a_no_insert_in_clear, r_clr_active, !i_wr_en)

endmodule

// ===== rtl/dnr_csum.sv =====
// Incremental IP and L4 checksum update (HC' = ~(~HC + ~m + m')), two stages.
// Depends on dnr_pkg for t_csum_req; results follow the operands in the next cycle.
module dnr_csum (
    input  logic                i_clk,
    input  dnr_pkg::t_csum_req  i_req,
    output logic [15:0]         o_ip_csum,
    output logic [15:0]         o_l4_csum
);

    logic [15:0] w_nhc_ip;
    logic [15:0] w_nhc_l4;
    logic [15:0] w_nold_hi;
    logic [15:0] w_nold_lo;
    logic [15:0] w_nold_port;
    logic [18:0] w_addr_part;
    logic [18:0] r_ip_sum;
    logic [18:0] r_l4_sum;
    logic [16:0] w_ip_f1;
    logic [16:0] w_ip_f2;
    logic [16:0] w_l4_f1;
    logic [16:0] w_l4_f2;

    assign w_nhc_ip    = ~i_req.hc_ip;
    assign w_nhc_l4    = ~i_req.hc_l4;
    assign w_nold_hi   = ~i_req.old_ip[31:16];
    assign w_nold_lo   = ~i_req.old_ip[15:0];
    assign w_nold_port = ~i_req.old_port;

    // Address contribution is shared by both sums.
    assign w_addr_part = 19'(w_nold_hi) + 19'(w_nold_lo)
                       + 19'(i_req.new_ip[31:16]) + 19'(i_req.new_ip[15:0]);

    // Stage one: unfolded one's-complement sums.
    always_ff @(posedge i_clk) begin
        r_ip_sum <= 19'(w_nhc_ip) + w_addr_part;
        r_l4_sum <= 19'(w_nhc_l4) + w_addr_part + 19'(w_nold_port) + 19'(i_req.new_port);
    end

    // Stage two: fold the carries twice and complement.
    assign w_ip_f1   = 17'(r_ip_sum[15:0]) + 17'(r_ip_sum[18:16]);
    assign w_ip_f2   = 17'(w_ip_f1[15:0]) + 17'(w_ip_f1[16]);
    assign w_l4_f1   = 17'(r_l4_sum[15:0]) + 17'(r_l4_sum[18:16]);
    assign w_l4_f2   = 17'(w_l4_f1[15:0]) + 17'(w_l4_f1[16]);
    assign o_ip_csum = ~w_ip_f2[15:0];
    assign o_l4_csum = ~w_l4_f2[15:0];

endmodule

// ===== rtl/dns_redirect_nat_rewriter_unit.sv =====
// Top level of the DNS redirect NAT rewriter: item sequencer, counters, outputs.
// Depends on dnr_pkg, dnr_apb_regs, dnr_flow_hash, dnr_flow_table, dnr_csum and macros.
//
// Usage:
//   Input channel: drive the header fields with start high; the item is taken at a
//   rising edge where start is high and busy is low. busy stays high while an item
//   is in flight and during the flow table clearing sweep after reset.
//   Result channel: o_valid is high for exactly one cycle with the rewritten header,
//   checksums, mark and counter values; the receiver must take it in that cycle.
//   Sequencing: the result shows when the sequencer returns to idle. busy drops
//   in that same cycle, so a new item can be taken while the result is shown, but
//   not before. The item passes the index pipeline (fold, reciprocal multiply,
//   remainder correction), the registered table read, and the two-stage checksum
//   unit, all worked through one item at a time.
//   Reset: synchronous, active low. Counters clear to zero, the mark register to
//   0x66, and the flow table is swept invalid, one row per cycle, over all FLOW_ENTRIES
//   rows, while busy is high; APB writes are accepted throughout.
//   Configuration: APB, registers at byte addresses 0, 4, 8, 12; write only while
//   the block is idle.
`include "dns_redirect_nat_rewriter_unit_macros.svh"
module dns_redirect_nat_rewriter_unit #(
    parameter int FLOW_ENTRIES = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input channel.
    input  logic        start,
    output logic        busy,
    input  logic        i_req_type,
    input  logic        i_header_ok,
    input  logic [3:0]  i_ip_version,
    input  logic [3:0]  i_header_words,
    input  logic [7:0]  i_protocol,
    input  logic [31:0] i_src_ip,
    input  logic [31:0] i_dst_ip,
    input  logic [15:0] i_src_port,
    input  logic [15:0] i_dst_port,
    input  logic [15:0] i_ip_csum,
    input  logic [15:0] i_l4_csum,
    input  logic [15:0] i_packet_len,
    // Result channel.
    output logic        o_valid,
    output logic [31:0] o_out_src_ip,
    output logic [31:0] o_out_dst_ip,
    output logic [15:0] o_out_src_port,
    output logic [15:0] o_out_dst_port,
    output logic [15:0] o_out_ip_csum,
    output logic [15:0] o_out_l4_csum,
    output logic        o_rewritten,
    output logic [31:0] o_out_mark,
    output logic [63:0] o_total_packets,
    output logic [63:0] o_total_bytes
);

    localparam int IDX_W = $clog2(FLOW_ENTRIES);

    typedef enum logic [2:0] {
        S_IDLE,
        S_HASH1,
        S_HASH2,
        S_HASH3,
        S_LOOK,
        S_SUM,
        S_FIN
    } t_state;

    typedef struct packed {
        logic        req_type;
        logic        header_ok;
        logic [3:0]  ip_version;
        logic [3:0]  header_words;
        logic [7:0]  protocol;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [15:0] ip_csum;
        logic [15:0] l4_csum;
        logic [15:0] packet_len;
    } t_item;

    t_state               r_state;
    t_state               n_state;
    t_item                r_item;
    dnr_pkg::t_cfg        w_cfg;
    dnr_pkg::t_csum_req   r_creq;
    dnr_pkg::t_csum_req   n_creq;
    dnr_pkg::t_flow_entry w_rd_entry;
    dnr_pkg::t_flow_entry w_wr_entry;
    logic                 r_rew;
    logic                 r_valid;
    logic [63:0]          r_pkt_cnt;
    logic [63:0]          r_byte_cnt;
    logic                 w_clearing;
    logic                 w_acc;
    logic                 w_egress;
    logic [31:0]          w_key_ip;
    logic [15:0]          w_key_port;
    logic [IDX_W-1:0]     w_idx;
    logic                 w_elig;
    logic                 w_ins;
    logic                 w_cand;
    logic                 w_hit;
    logic                 w_do_l4;
    logic [15:0]          w_ip_fin;
    logic [15:0]          w_l4_fin;

    // Configuration registers.
    dnr_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Client key: source on ingress, destination on egress.
    assign w_egress   = (r_item.req_type == dnr_pkg::REQ_EGRESS);
    assign w_key_ip   = w_egress ? r_item.dst_ip : r_item.src_ip;
    assign w_key_port = w_egress ? r_item.dst_port : r_item.src_port;

    dnr_flow_hash #(
        .FLOW_ENTRIES (FLOW_ENTRIES)
    ) u_hash (
        .i_clk       (i_clk),
        .i_key_ip    (w_key_ip),
        .i_key_port  (w_key_port),
        .i_key_proto (r_item.protocol),
        .o_idx       (w_idx)
    );

    // Insert row for a redirected ingress query.
    assign w_wr_entry.valid       = 1'b1;
    assign w_wr_entry.key_tag     = dnr_pkg::flow_key(r_item.src_ip, r_item.src_port,
                                                      r_item.protocol);
    assign w_wr_entry.orig_server = {r_item.dst_ip, r_item.dst_port};

    dnr_flow_table #(
        .FLOW_ENTRIES (FLOW_ENTRIES)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (r_state == S_HASH3),
        .i_rd_idx   (w_idx),
        .o_rd_entry (w_rd_entry),
        .i_wr_en    ((r_state == S_LOOK) && w_ins),
        .i_wr_idx   (w_idx),
        .i_wr_entry (w_wr_entry),
        .o_clearing (w_clearing)
    );

    dnr_csum u_csum (
        .i_clk     (i_clk),
        .i_req     (r_creq),
        .o_ip_csum (w_ip_fin),
        .o_l4_csum (w_l4_fin)
    );

    // Handshake.
    assign busy  = (r_state != S_IDLE) || w_clearing;
    assign w_acc = start && !busy;

    // Eligibility, insert and lookup decisions.
    assign w_elig = w_cfg.redirect_enable && r_item.header_ok
                  && (r_item.ip_version == dnr_pkg::IP_V4)
                  && (r_item.header_words >= dnr_pkg::MIN_IHL)
                  && ((r_item.protocol == dnr_pkg::PROTO_UDP)
                      || (r_item.protocol == dnr_pkg::PROTO_TCP));
    assign w_ins  = !w_egress && w_elig && (r_item.dst_port == dnr_pkg::DNS_PORT);
    assign w_cand = w_egress && w_elig && (r_item.src_ip == w_cfg.server_ip)
                  && (r_item.src_port == w_cfg.server_port);
    assign w_hit  = w_cand && w_rd_entry.valid
                  && (w_rd_entry.key_tag == dnr_pkg::flow_key(r_item.dst_ip, r_item.dst_port,
                                                              r_item.protocol));
    // A UDP checksum of zero means none and is left alone.
    assign w_do_l4 = (r_item.protocol != dnr_pkg::PROTO_UDP) || (r_item.l4_csum != 16'd0);

    // Checksum operands: destination swap on ingress, source restore on egress.
    always_comb begin
        n_creq.hc_ip = r_item.ip_csum;
        n_creq.hc_l4 = r_item.l4_csum;
        if (w_egress) begin
            n_creq.old_ip   = r_item.src_ip;
            n_creq.new_ip   = w_rd_entry.orig_server[47:16];
            n_creq.old_port = r_item.src_port;
            n_creq.new_port = w_rd_entry.orig_server[15:0];
        end else begin
            n_creq.old_ip   = r_item.dst_ip;
            n_creq.new_ip   = w_cfg.server_ip;
            n_creq.old_port = r_item.dst_port;
            n_creq.new_port = w_cfg.server_port;
        end
    end

    // Next state.
    always_comb begin
        case (r_state)
            S_IDLE:  n_state = w_acc ? S_HASH1 : S_IDLE;
            S_HASH1: n_state = S_HASH2;
            S_HASH2: n_state = S_HASH3;
            S_HASH3: n_state = S_LOOK;
            S_LOOK:  n_state = S_SUM;
            S_SUM:   n_state = S_FIN;
            S_FIN:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Sequencer state, counters, item capture and result registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_valid    <= 1'b0;
            r_pkt_cnt  <= 64'd0;
            r_byte_cnt <= 64'd0;
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == S_FIN);
            if (w_acc) begin
                r_item.req_type     <= i_req_type;
                r_item.header_ok    <= i_header_ok;
                r_item.ip_version   <= i_ip_version;
                r_item.header_words <= i_header_words;
                r_item.protocol     <= i_protocol;
                r_item.src_ip       <= i_src_ip;
                r_item.dst_ip       <= i_dst_ip;
                r_item.src_port     <= i_src_port;
                r_item.dst_port     <= i_dst_port;
                r_item.ip_csum      <= i_ip_csum;
                r_item.l4_csum      <= i_l4_csum;
                r_item.packet_len   <= i_packet_len;
            end
            if (r_state == S_LOOK) begin
                r_rew  <= w_ins || w_hit;
                r_creq <= n_creq;
                if (!w_egress) begin
                    r_pkt_cnt  <= r_pkt_cnt + 64'd1;
                    r_byte_cnt <= r_byte_cnt + 64'(r_item.packet_len);
                end
            end
            if (r_state == S_FIN) begin
                o_out_src_ip    <= (r_rew && w_egress) ? r_creq.new_ip : r_item.src_ip;
                o_out_src_port  <= (r_rew && w_egress) ? r_creq.new_port : r_item.src_port;
                o_out_dst_ip    <= (r_rew && !w_egress) ? r_creq.new_ip : r_item.dst_ip;
                o_out_dst_port  <= (r_rew && !w_egress) ? r_creq.new_port : r_item.dst_port;
                o_out_ip_csum   <= r_rew ? w_ip_fin : r_item.ip_csum;
                o_out_l4_csum   <= (r_rew && w_do_l4) ? w_l4_fin : r_item.l4_csum;
                o_rewritten     <= r_rew;
                o_out_mark      <= w_egress ? 32'd0 : w_cfg.packet_mark;
                o_total_packets <= r_pkt_cnt;
                o_total_bytes   <= r_byte_cnt;
            end
        end
    end

    assign o_valid = r_valid;

    // A result is a single-cycle strobe.
    `DNR_ASSERT_NXT(a_valid_single, o_valid, !o_valid)
    // No item is ever in flight while the table is being cleared.
    `DNR_ASSERT_IMP(a_no_item_in_clear, r_state != S_IDLE, !w_clearing)
    // A packet that is not rewritten keeps its checksum and destination.
    `DNR_ASSERT_IMP(a_pass_keeps_hdr, o_valid && !o_rewritten,
                    (o_out_ip_csum == r_item.ip_csum) && (o_out_dst_ip == r_item.dst_ip))

endmodule
